FILE: rtl/assert_macros.svh
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on clk_i / rst_ni.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define CBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/cbc_pkg.sv
// ------------------------------------------------------------------------
// cbc_pkg
// Types and constants of the cartridge bank controller.
// ------------------------------------------------------------------------
package cbc_pkg;

  localparam int unsigned RamDepthDefault = 32768;

  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned RomAddrW = 19;
  localparam int unsigned RomOffW  = 14;  // 16 KiB ROM bank
  localparam int unsigned RamOffW  = 13;  // 8 KiB RAM bank
  localparam int unsigned RomSelW  = 5;
  localparam int unsigned RamSelW  = 8;
  localparam int unsigned RamRaW   = RamSelW + RamOffW;
  localparam int unsigned RomBanksW = 6;
  localparam int unsigned RamBytesW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [RomBanksW-1:0] RomBanksReset = 6'd32;
  localparam logic [RamBytesW-1:0] RamBytesReset = 16'd32768;
  localparam logic [RomSelW-1:0]   RomSelReset   = 5'd1;

  localparam logic [3:0]       EnableKey  = 4'hA;
  localparam logic [DataW-1:0] DisabledRd = 8'hFF;

  // bus_addr[15:13] regions
  localparam logic [2:0] RegionEnable  = 3'b000;
  localparam logic [2:0] RegionRomBank = 3'b001;
  localparam logic [2:0] RegionRamBank = 3'b010;
  localparam logic [2:0] RegionRam     = 3'b101;

  localparam logic [CfgIdxW-1:0] CfgRomBanks = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRamBytes = 2'd1;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_UNKNOWN = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_e;

  typedef struct packed {
    logic               ram_en_we;
    logic               ram_en_val;
    logic               rom_sel_we;
    logic [RomSelW-1:0] rom_sel_val;
    logic               ram_sel_we;
    logic               mem_we;
    logic               mem_re;
  } cbc_ctrl_t;

  typedef struct packed {
    logic [DataW-1:0]    rd_data;
    logic                rom_fetch;
    logic [RomAddrW-1:0] rom_address;
    status_e             status;
  } cbc_res_t;

endpackage

FILE: rtl/cbc_if.sv
// ------------------------------------------------------------------------
// cbc_req_if / cbc_rsp_if
// Valid/ready channels for bus accesses and their results.
// ------------------------------------------------------------------------
interface cbc_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] bus_addr;
  logic [7:0]  wr_data;

  modport source (output valid, output op, output bus_addr, output wr_data, input ready);
  modport sink   (input valid, input op, input bus_addr, input wr_data, output ready);
endinterface

interface cbc_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rd_data;
  logic        rom_fetch;
  logic [18:0] rom_address;
  logic [1:0]  status;

  modport source (output valid, output rd_data, output rom_fetch, output rom_address,
                  output status, input ready);
  modport sink   (input valid, input rd_data, input rom_fetch, input rom_address,
                  input status, output ready);
endinterface

FILE: rtl/cbc_decode.sv
// ------------------------------------------------------------------------
// cbc_decode
// Address decode, bank translation and size checks for one access.
// ------------------------------------------------------------------------
module cbc_decode #(
  parameter int unsigned RAM_DEPTH = cbc_pkg::RamDepthDefault,
  localparam int unsigned MemAw    = $clog2(RAM_DEPTH)
) (
  input  logic                          op_i,
  input  logic [cbc_pkg::AddrW-1:0]     bus_addr_i,
  input  logic [cbc_pkg::DataW-1:0]     wr_data_i,
  input  logic                          ram_en_i,
  input  logic [cbc_pkg::RomSelW-1:0]   rom_sel_i,
  input  logic [cbc_pkg::RamSelW-1:0]   ram_sel_i,
  input  logic [cbc_pkg::RomBanksW-1:0] rom_banks_i,
  input  logic [cbc_pkg::RamBytesW-1:0] ram_bytes_i,
  output cbc_pkg::cbc_ctrl_t            ctrl_o,
  output cbc_pkg::cbc_res_t             res_o,
  output logic [MemAw-1:0]              mem_addr_o
);
  import cbc_pkg::*;

  localparam logic [RamRaW-1:0] RamDepthC = RamRaW'(RAM_DEPTH);

  logic [2:0]           region;
  logic [RamRaW-1:0]    ram_ra;
  logic                 ram_in;
  logic [RomBanksW-1:0] fetch_bank;

  assign region     = bus_addr_i[AddrW-1 -: 3];
  assign ram_ra     = {ram_sel_i, bus_addr_i[RamOffW-1:0]};
  assign ram_in     = (ram_ra < RamRaW'(ram_bytes_i)) && (ram_ra < RamDepthC);
  assign mem_addr_o = ram_ra[MemAw-1:0];
  // bank 0 area is fixed, 0x4000-0x7FFF uses the selected bank
  assign fetch_bank = bus_addr_i[RomOffW] ? {1'b0, rom_sel_i} : '0;

  always_comb begin
    ctrl_o = '0;
    ctrl_o.ram_en_val  = (wr_data_i[3:0] == EnableKey);
    ctrl_o.rom_sel_val = (wr_data_i[RomSelW-1:0] == '0) ? RomSelReset
                                                        : wr_data_i[RomSelW-1:0];
    res_o = '0;
    res_o.status = STATUS_OK;
    if (op_i == OP_WRITE) begin
      priority if (region == RegionEnable) begin
        ctrl_o.ram_en_we = 1'b1;
      end else if (region == RegionRomBank) begin
        ctrl_o.rom_sel_we = 1'b1;
      end else if (region == RegionRamBank) begin
        ctrl_o.ram_sel_we = 1'b1;
      end else if (region == RegionRam) begin
        if (ram_en_i) begin
          if (ram_in) ctrl_o.mem_we = 1'b1;
          else        res_o.status  = STATUS_RANGE;
        end
      end else begin
        res_o.status = STATUS_UNKNOWN;
      end
    end else begin
      priority if (!bus_addr_i[AddrW-1]) begin
        if (fetch_bank < rom_banks_i) begin
          res_o.rom_fetch   = 1'b1;
          res_o.rom_address = {fetch_bank[RomSelW-1:0], bus_addr_i[RomOffW-1:0]};
        end else begin
          res_o.status = STATUS_RANGE;
        end
      end else if (region == RegionRam) begin
        if (!ram_en_i)   res_o.rd_data = DisabledRd;
        else if (ram_in) ctrl_o.mem_re = 1'b1;
        else             res_o.status  = STATUS_RANGE;
      end else begin
        res_o.status = STATUS_UNKNOWN;
      end
    end
  end

endmodule

FILE: rtl/cbc_ram.sv
// ------------------------------------------------------------------------
// cbc_ram
// Cartridge RAM, one write or one registered read per cycle.
// ------------------------------------------------------------------------
module cbc_ram #(
  parameter int unsigned RAM_DEPTH = cbc_pkg::RamDepthDefault,
  localparam int unsigned MemAw    = $clog2(RAM_DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [MemAw-1:0]           addr_i,
  input  logic [cbc_pkg::DataW-1:0]  wdata_i,
  output logic [cbc_pkg::DataW-1:0]  rdata_o
);
  import cbc_pkg::*;

  logic [DataW-1:0] mem [RAM_DEPTH];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
  end

  // read data holds until the next read, so a stalled result keeps its byte
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cartridge_bank_controller_core.sv
// ------------------------------------------------------------------------
// cartridge_bank_controller_core
// Banked cartridge controller: bank registers, RAM and result register.
// ------------------------------------------------------------------------
// Usage:
//   req_i carries one CPU bus access per beat (op, bus_addr, wr_data).
//   rsp_o returns one result beat per access, in order: rd_data,
//   rom_fetch/rom_address for external ROM reads, and status.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write rom_banks (index 0) and
//   ram_bytes (index 1); other indexes are ignored. Write only when idle.
// Timing:
//   The result is valid the cycle after the request beat. Throughput is one
//   access per cycle while the receiver does not stall, set by the single
//   result register and the one-port cart RAM (write or registered read).
// Stall:
//   req_i.ready is high while the result register is empty or is being
//   drained; a stalled receiver holds the result and blocks new requests.
// Reset:
//   rst_ni clears the valid flag, RAM enable (off), ROM bank (1), RAM bank
//   (0) and restores rom_banks 32 and ram_bytes 32768. RAM contents are not
//   cleared; read only locations written earlier.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module cartridge_bank_controller_core #(
  parameter int unsigned RAM_DEPTH = cbc_pkg::RamDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cbc_req_if.sink                       req_i,
  cbc_rsp_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [cbc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cbc_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import cbc_pkg::*;

  localparam int unsigned MemAw = $clog2(RAM_DEPTH);

  logic [RomBanksW-1:0] rom_banks_q;
  logic [RamBytesW-1:0] ram_bytes_q;
  logic                 ram_en_q;
  logic [RomSelW-1:0]   rom_sel_q;
  logic [RamSelW-1:0]   ram_sel_q;
  logic                 out_valid_q;
  logic                 from_mem_q;
  cbc_res_t             res_q;

  cbc_ctrl_t        ctrl;
  cbc_res_t         res;
  logic [MemAw-1:0] mem_addr;
  logic [DataW-1:0] mem_rdata;
  logic             accept;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  cbc_decode #(.RAM_DEPTH(RAM_DEPTH)) u_decode (
    .op_i        (req_i.op),
    .bus_addr_i  (req_i.bus_addr),
    .wr_data_i   (req_i.wr_data),
    .ram_en_i    (ram_en_q),
    .rom_sel_i   (rom_sel_q),
    .ram_sel_i   (ram_sel_q),
    .rom_banks_i (rom_banks_q),
    .ram_bytes_i (ram_bytes_q),
    .ctrl_o      (ctrl),
    .res_o       (res),
    .mem_addr_o  (mem_addr)
  );

  cbc_ram #(.RAM_DEPTH(RAM_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (accept && ctrl.mem_we),
    .re_i    (accept && ctrl.mem_re),
    .addr_i  (mem_addr),
    .wdata_i (req_i.wr_data),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_banks_q <= RomBanksReset;
      ram_bytes_q <= RamBytesReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgRomBanks) rom_banks_q <= cfg_wdata_i[RomBanksW-1:0];
      if (cfg_idx_i == CfgRamBytes) ram_bytes_q <= cfg_wdata_i[RamBytesW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_en_q  <= 1'b0;
      rom_sel_q <= RomSelReset;
      ram_sel_q <= '0;
    end else if (accept) begin
      if (ctrl.ram_en_we)  ram_en_q  <= ctrl.ram_en_val;
      if (ctrl.rom_sel_we) rom_sel_q <= ctrl.rom_sel_val;
      if (ctrl.ram_sel_we) ram_sel_q <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      out_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q      <= res;
      from_mem_q <= ctrl.mem_re;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.rd_data     = from_mem_q ? mem_rdata : res_q.rd_data;
  assign rsp_o.rom_fetch   = res_q.rom_fetch;
  assign rsp_o.rom_address = res_q.rom_address;
  assign rsp_o.status      = res_q.status;

  `CBC_ASSERT(a_rom_sel_nonzero, rom_sel_q != '0, "ROM bank select is zero")
  `CBC_ASSERT(a_fetch_ok, (out_valid_q && res_q.rom_fetch) |-> (res_q.status == STATUS_OK), "ROM fetch with bad status")
  `CBC_ASSERT(a_write_rsp, (accept && req_i.op == OP_WRITE) |=> (rsp_o.valid && rsp_o.rd_data == '0 && !rsp_o.rom_fetch), "write result not clean")

endmodule

FILE: tb/cartridge_bank_controller_core_tb.sv
// ------------------------------------------------------------------------
// cartridge_bank_controller_core_tb
// Self-checking bench for the cartridge bank controller: bus accesses go in
// over req_i, and each result beat on rsp_o is checked against an in-bench
// model of the bank registers and cart RAM. Directed bank and boundary
// accesses run first, then random traffic under several size settings,
// with random idling on both sides and one long receiver hold-off.
// ------------------------------------------------------------------------
module cartridge_bank_controller_core_tb;
  import cbc_pkg::*;

  localparam int unsigned RamDepth     = RamDepthDefault;
  localparam int unsigned RomBankBytes = 16384;
  localparam int unsigned RamBankBytes = 8192;
  localparam int unsigned CycleLimit   = 200000;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd2;  // no register behind it
  localparam logic [CfgIdxW-1:0] CfgNone  = 2'd3;  // no register behind it

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  cbc_req_if req_ch ();
  cbc_rsp_if rsp_ch ();

  cartridge_bank_controller_core #(
    .RAM_DEPTH(RamDepth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // model of the controller state
  logic [RomBanksW-1:0] rom_banks_q;
  logic [RamBytesW-1:0] ram_bytes_q;
  logic                 ram_en_q;
  logic [RomSelW-1:0]   rom_sel_q;
  logic [RamSelW-1:0]   ram_sel_q;
  logic [7:0]           ram_image [int unsigned];

  cbc_res_t    pending_res_q[$];
  cbc_res_t    head_res;
  int unsigned error_count;
  int unsigned beat_count;
  int unsigned cycle_count;
  int unsigned hold_cycles;
  bit          quiet;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------
  function automatic int unsigned ram_limit();
    return (ram_bytes_q < RamDepth) ? ram_bytes_q : RamDepth;
  endfunction

  function automatic int unsigned ram_index(logic [15:0] addr);
    return ram_sel_q * RamBankBytes + addr[12:0];
  endfunction

  function automatic cbc_res_t predict_access(op_e op, logic [15:0] addr, logic [7:0] data);
    cbc_res_t    res;
    int unsigned rom_idx;
    res = '{rd_data: '0, rom_fetch: 1'b0, rom_address: '0, status: STATUS_OK};
    if (op == OP_WRITE) begin
      case (addr[15:13])
        RegionEnable:  ram_en_q = (data[3:0] == EnableKey);
        RegionRomBank: rom_sel_q = (data[4:0] == '0) ? 5'd1 : data[4:0];
        RegionRamBank: ram_sel_q = data;
        RegionRam: begin
          // dropped silently while disabled
          if (ram_en_q) begin
            if (ram_index(addr) < ram_limit()) ram_image[ram_index(addr)] = data;
            else res.status = STATUS_RANGE;
          end
        end
        default: res.status = STATUS_UNKNOWN;
      endcase
    end else if (!addr[15]) begin
      rom_idx = addr[14] ? rom_sel_q * RomBankBytes + addr[13:0] : addr[14:0];
      if (rom_idx < rom_banks_q * RomBankBytes) begin
        res.rom_fetch   = 1'b1;
        res.rom_address = rom_idx[RomAddrW-1:0];
      end else begin
        res.status = STATUS_RANGE;
      end
    end else if (addr[15:13] == RegionRam) begin
      if (!ram_en_q) res.rd_data = DisabledRd;
      else if (ram_index(addr) < ram_limit()) res.rd_data = ram_image[ram_index(addr)];
      else res.status = STATUS_RANGE;
    end else begin
      res.status = STATUS_UNKNOWN;
    end
    return res;
  endfunction

  function automatic bit reads_unwritten(op_e op, logic [15:0] addr);
    return op == OP_READ && addr[15:13] == RegionRam && ram_en_q &&
           ram_index(addr) < ram_limit() && !ram_image.exists(ram_index(addr));
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  task automatic send_access(input op_e op, input logic [15:0] addr, input logic [7:0] data);
    while (!quiet && $urandom_range(0, 99) < 19) begin
      req_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid    = 1'b1;
    req_ch.op       = op;
    req_ch.bus_addr = addr;
    req_ch.wr_data  = data;
    do @(posedge clk_i); while (!req_ch.ready);
    pending_res_q.push_back(predict_access(op, addr, data));
    @(negedge clk_i);
    req_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_res_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    if (idx == CfgRomBanks) rom_banks_q = value[RomBanksW-1:0];
    else if (idx == CfgRamBytes) ram_bytes_q = value;
  endtask

  task automatic set_sizes(input int unsigned banks, input int unsigned bytes);
    write_reg(CfgRomBanks, CfgDataW'(banks));
    write_reg(CfgRamBytes, CfgDataW'(bytes));
  endtask

  // mostly the low and high corners of a RAM bank so reads find data
  function automatic logic [12:0] ram_offset();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 70) return 13'($urandom_range(0, 31));
    if (k < 85) return 13'($urandom_range(8160, 8191));
    return 13'($urandom_range(0, 8191));
  endfunction

  task automatic gen_access(output op_e op, output logic [15:0] addr, output logic [7:0] data);
    int unsigned k;
    k    = $urandom_range(0, 99);
    data = 8'($urandom_range(0, 255));
    op   = OP_WRITE;
    if (k < 28) begin
      op   = OP_READ;
      addr = 16'($urandom_range(0, 'h7FFF));
    end else if (k < 36) begin
      addr = 16'($urandom_range(0, 'h1FFF));
      if ($urandom_range(0, 3) != 0) data[3:0] = EnableKey;
    end else if (k < 43) begin
      addr = 16'($urandom_range('h2000, 'h3FFF));
    end else if (k < 50) begin
      addr = 16'($urandom_range('h4000, 'h5FFF));
      if ($urandom_range(0, 3) != 0) data = 8'($urandom_range(0, 4));
    end else if (k < 72) begin
      addr = 16'hA000 + ram_offset();
    end else if (k < 92) begin
      op   = OP_READ;
      addr = 16'hA000 + ram_offset();
    end else begin
      case ($urandom_range(0, 3))
        0: begin op = OP_READ; addr = 16'($urandom_range('h8000, 'h9FFF)); end
        1: begin op = OP_READ; addr = 16'($urandom_range('hC000, 'hFFFF)); end
        2: addr = 16'($urandom_range('h6000, 'h9FFF));
        default: addr = 16'($urandom_range('hC000, 'hFFFF));
      endcase
    end
    // a never-written RAM entry must not be read: store to it instead
    if (reads_unwritten(op, addr)) op = OP_WRITE;
  endtask

  task automatic run_random(input int unsigned n);
    op_e         op;
    logic [15:0] addr;
    logic [7:0]  data;
    repeat (n) begin
      gen_access(op, addr, data);
      send_access(op, addr, data);
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      rsp_ch.ready = 1'b0;
      hold_cycles  = hold_cycles - 1;
    end else if (quiet) begin
      rsp_ch.ready = 1'b1;
    end else begin
      rsp_ch.ready = ($urandom_range(0, 99) >= 19);
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR: beat %0d %s got 0x%0h expected 0x%0h", beat_count, field, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_res_q.size() == 0) begin
        report_mismatch("unexpected result beat", 32'(rsp_ch.status), 0);
      end else begin
        head_res = pending_res_q.pop_front();
        if (rsp_ch.rd_data !== head_res.rd_data)
          report_mismatch("rd_data", 32'(rsp_ch.rd_data), 32'(head_res.rd_data));
        if (rsp_ch.rom_fetch !== head_res.rom_fetch)
          report_mismatch("rom_fetch", 32'(rsp_ch.rom_fetch), 32'(head_res.rom_fetch));
        if (rsp_ch.rom_address !== head_res.rom_address)
          report_mismatch("rom_address", 32'(rsp_ch.rom_address),
                          32'(head_res.rom_address));
        if (rsp_ch.status !== head_res.status)
          report_mismatch("status", 32'(rsp_ch.status), 32'(head_res.status));
      end
      beat_count++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_bank_mapping();
    send_access(OP_READ,  16'h0000, 8'h00);
    send_access(OP_READ,  16'h3FFF, 8'hFF);
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    send_access(OP_WRITE, 16'h2000, 8'h00);  // bank 0 maps to 1
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_WRITE, 16'h3FFF, 8'hFF);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    send_access(OP_READ,  16'hA000, 8'h00);  // disabled RAM
    send_access(OP_WRITE, 16'hBFFF, 8'h55);
    send_access(OP_WRITE, 16'h1FFF, 8'h3A);
    send_access(OP_WRITE, 16'hA000, 8'h00);
    send_access(OP_WRITE, 16'hBFFF, 8'hFF);
    send_access(OP_READ,  16'hA000, 8'h00);
    send_access(OP_READ,  16'hBFFF, 8'h00);
    send_access(OP_WRITE, 16'h5FFF, 8'hFF);
    send_access(OP_WRITE, 16'hA000, 8'h12);  // far past RAM
    send_access(OP_READ,  16'hBFFF, 8'h00);
    send_access(OP_WRITE, 16'h4000, 8'h00);
    send_access(OP_READ,  16'h8000, 8'h00);
    send_access(OP_READ,  16'hFFFF, 8'h00);
    send_access(OP_WRITE, 16'h6000, 8'hA5);
    send_access(OP_WRITE, 16'h9FFF, 8'h5A);
    send_access(OP_WRITE, 16'hC000, 8'hFF);
    send_access(OP_WRITE, 16'h0000, 8'h0B);
  endtask

  task automatic test_size_limits();
    set_sizes(2, 0);
    send_access(OP_WRITE, 16'h1FFF, 8'h0A);
    send_access(OP_READ,  16'h3FFF, 8'h00);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    send_access(OP_WRITE, 16'h2000, 8'h01);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    send_access(OP_WRITE, 16'h2000, 8'h02);
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_READ,  16'hA000, 8'h00);
    send_access(OP_WRITE, 16'hA000, 8'h77);
    set_sizes(32, 8192);
    send_access(OP_WRITE, 16'hBFFF, 8'h81);
    send_access(OP_READ,  16'hBFFF, 8'h00);
    send_access(OP_WRITE, 16'h4000, 8'h01);
    send_access(OP_WRITE, 16'hA000, 8'h42);
    // unused indexes must not disturb the size registers
    write_reg(CfgNone, 16'hFFFF);
    write_reg(CfgSpare, 16'h0000);
    send_access(OP_READ,  16'h4000, 8'h00);
    set_sizes(32, 32768);
    send_access(OP_WRITE, 16'h4000, 8'h03);
    send_access(OP_WRITE, 16'hBFFF, 8'hC3);
    send_access(OP_READ,  16'hBFFF, 8'h00);
    send_access(OP_WRITE, 16'h4000, 8'h04);
    send_access(OP_READ,  16'hA000, 8'h00);
    send_access(OP_WRITE, 16'h2000, 8'h1F);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    run_random(80);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_sizes(32, 32768);
        1: set_sizes(2, 0);
        2: set_sizes(32, 0);
        3: set_sizes(2, 32768);
        default: set_sizes($urandom_range(2, 32), $urandom_range(0, 32768));
      endcase
      run_random(200);
    end
  endtask

  task automatic test_no_idle_stretch();
    set_sizes(32, 32768);
    quiet = 1'b1;
    run_random(250);
    wait_idle();
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    set_sizes($urandom_range(2, 32), $urandom_range(8192, 32768));
    hold_cycles = 150;
    run_random(150);
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CfgRomBanks;
    cfg_wdata       = '0;
    req_ch.valid    = 1'b0;
    req_ch.op       = OP_READ;
    req_ch.bus_addr = '0;
    req_ch.wr_data  = '0;
    rsp_ch.ready    = 1'b0;
    quiet           = 1'b0;
    hold_cycles     = 0;
    error_count     = 0;
    beat_count      = 0;
    cycle_count     = 0;
    rom_banks_q     = RomBanksReset;
    ram_bytes_q     = RamBytesReset;
    ram_en_q        = 1'b0;
    rom_sel_q       = RomSelReset;
    ram_sel_q       = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_bank_mapping();
    test_size_limits();
    test_random_traffic();
    test_no_idle_stretch();
    test_backpressure();

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (error_count == 0 && pending_res_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
